>>> sv/bgh_pkg.sv
// Constants, config register indexes and the voltage-to-charge curve for the battery gauge.
package bgh_pkg;

    typedef logic [0:0] t_cfg_index;

    localparam t_cfg_index CFG_MONITOR_ENABLE  = 1'd0;
    localparam t_cfg_index CFG_UPDATE_INTERVAL = 1'd1;

    localparam logic        RST_MONITOR_ENABLE  = 1'b1;
    localparam logic [31:0] RST_UPDATE_INTERVAL = 32'd60000;
    localparam logic [6:0]  RST_LEVEL           = 7'd100;

    localparam logic signed [13:0] FULL_MV   = 14'sd4200;
    localparam logic signed [13:0] EMPTY_MV  = 14'sd3450;
    localparam logic signed [13:0] KNEE_A_MV = 14'sd4100;
    localparam logic signed [13:0] KNEE_B_MV = 14'sd4000;
    localparam logic signed [13:0] KNEE_C_MV = 14'sd3850;
    localparam logic signed [13:0] KNEE_D_MV = 14'sd3700;
    localparam logic signed [13:0] KNEE_E_MV = 14'sd3550;

    localparam logic signed [24:0] ADC_SCALE = 25'sd1200;
    localparam logic signed [13:0] VDDHDIV   = 14'sd5;
    localparam logic signed [7:0]  HYST_STEP = 8'sd2;

    // reciprocals: x*205>>11 = x/10 and x*2185>>15 = x/15 over the offsets used here
    localparam logic [15:0] RECIP_10 = 16'd205;
    localparam logic [20:0] RECIP_15 = 21'd2185;

    function automatic logic [6:0] mv_to_pct(input logic signed [13:0] mv);
        logic signed [13:0] d;
        logic [7:0]         u;
        logic [15:0]        p10;
        logic [20:0]        p15;
        logic [6:0]         pct;
        d = mv - EMPTY_MV;
        if (mv >= KNEE_A_MV) begin
            d = mv - KNEE_A_MV;
        end else if (mv >= KNEE_B_MV) begin
            d = mv - KNEE_B_MV;
        end else if (mv >= KNEE_C_MV) begin
            d = mv - KNEE_C_MV;
        end else if (mv >= KNEE_D_MV) begin
            d = mv - KNEE_D_MV;
        end else if (mv >= KNEE_E_MV) begin
            d = mv - KNEE_E_MV;
        end
        u   = d[7:0];
        p10 = 16'(u) * RECIP_10;
        p15 = 21'({u, 1'b0}) * RECIP_15;
        if (mv >= FULL_MV) begin
            pct = 7'd100;
        end else if (mv <= EMPTY_MV) begin
            pct = 7'd0;
        end else if (mv >= KNEE_A_MV) begin
            pct = 7'd90 + 7'(p10[15:11]);
        end else if (mv >= KNEE_B_MV) begin
            pct = 7'd70 + 7'(p10[15:10]);
        end else if (mv >= KNEE_C_MV) begin
            pct = 7'd40 + 7'(p10[15:10]);
        end else if (mv >= KNEE_D_MV) begin
            pct = 7'd20 + 7'(p15[20:15]);
        end else if (mv >= KNEE_E_MV) begin
            pct = 7'd5 + 7'(p10[15:11]);
        end else begin
            pct = 7'(p10[15:12]);
        end
        return pct;
    endfunction

endpackage

>>> sv/battery_gauge_hysteresis.sv
// Battery gauge: rate-limited supply sampling, charge curve and level hysteresis.
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-----------------------------------------
//  in      | i_in_valid  | o_in_stall  | i_now_ms, i_raw_sample, i_read_failed
//  out     | o_out_valid | i_out_stall | o_charge_percent, o_supply_mv, o_sampled
//  cfg     | i_cfg_we    | -           | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; an item passes through the input
// register, then the result register, with the gauge state updated on the edge that
// loads the result register.
// Synchronous active-low reset restores the register defaults and clears both stages.
// Output stall backs up through the result register into the input register.
module battery_gauge_hysteresis
    import bgh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_index         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_now_ms,
    input  logic signed [12:0] i_raw_sample,
    input  logic               i_read_failed,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [6:0]         o_charge_percent,
    output logic signed [13:0] o_supply_mv,
    output logic               o_sampled
);

    logic               r_enable;
    logic [31:0]        r_interval;
    logic [6:0]         r_level;
    logic signed [13:0] r_volt;
    logic [31:0]        r_last_time;
    logic               r_first;

    logic               r_in_valid;
    logic [31:0]        r_now;
    logic signed [12:0] r_raw;
    logic               r_failed;

    logic               r_out_valid;
    logic [6:0]         r_out_level;
    logic signed [13:0] r_out_volt;
    logic               r_out_sampled;

    logic               w_move;
    logic               w_accept;
    logic [31:0]        w_elapsed;
    logic               w_take;
    logic               w_good;
    logic signed [24:0] w_prod;
    logic signed [13:0] w_mv;
    logic [6:0]         w_pct;
    logic signed [7:0]  w_diff;
    logic               w_big;
    logic [6:0]         n_level;
    logic signed [13:0] n_volt;

    assign w_move     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_move;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_elapsed = r_now - r_last_time;
    assign w_take    = r_enable && (r_first || (w_elapsed >= r_interval));
    assign w_good    = w_take && !r_failed;
    assign w_prod    = 25'(r_raw) * ADC_SCALE;
    assign w_mv      = 14'($signed(w_prod[24:12])) * VDDHDIV;
    assign w_pct     = mv_to_pct(w_mv);
    assign w_diff    = $signed({1'b0, w_pct}) - $signed({1'b0, r_level});
    assign w_big     = (w_diff >= HYST_STEP) || (w_diff <= -HYST_STEP);

    always_comb begin
        n_level = r_level;
        n_volt  = r_volt;
        if (w_good) begin
            n_volt = w_mv;
            if (r_first || w_big) begin
                n_level = w_pct;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= RST_MONITOR_ENABLE;
            r_interval <= RST_UPDATE_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MONITOR_ENABLE:  r_enable   <= i_cfg_data[0];
                CFG_UPDATE_INTERVAL: r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= RST_LEVEL;
            r_volt      <= '0;
            r_last_time <= '0;
            r_first     <= 1'b1;
        end else if (w_move) begin
            r_level <= n_level;
            r_volt  <= n_volt;
            if (w_take) begin
                r_last_time <= r_now;
            end
            if (w_good) begin
                r_first <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_now    <= i_now_ms;
            r_raw    <= i_raw_sample;
            r_failed <= i_read_failed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_out_level   <= n_level;
            r_out_volt    <= n_volt;
            r_out_sampled <= w_good;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_charge_percent = r_out_level;
    assign o_supply_mv      = r_out_volt;
    assign o_sampled        = r_out_sampled;

endmodule

>>> sv/bgh_checker.sv
// Port-level checks for the battery gauge, bound to its top level.
module bgh_checker
    import bgh_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [6:0]         o_charge_percent,
    input logic signed [13:0] o_supply_mv,
    input logic               o_sampled
);

    localparam logic signed [13:0] MV_MIN = -14'sd6000;
    localparam logic signed [13:0] MV_MAX = 14'sd5995;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_charge_percent <= RST_LEVEL)
        else $error("charge level above full");

    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_supply_mv >= MV_MIN) && (o_supply_mv <= MV_MAX))
        else $error("supply millivolts out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_charge_percent)
            && $stable(o_supply_mv) && $stable(o_sampled))
        else $error("stalled result changed");

endmodule

bind battery_gauge_hysteresis bgh_checker u_bgh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_charge_percent (o_charge_percent),
    .o_supply_mv      (o_supply_mv),
    .o_sampled        (o_sampled)
);

>>> sim/tb_battery_gauge_hysteresis.sv
// Self-checking testbench for battery_gauge_hysteresis: curve, rate-limit and random traffic.
module tb_battery_gauge_hysteresis;
    import bgh_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    localparam int MV_FULL  = 4200;
    localparam int MV_EMPTY = 3450;
    localparam int MV_KNEE_A = 4100;
    localparam int MV_KNEE_B = 4000;
    localparam int MV_KNEE_C = 3850;
    localparam int MV_KNEE_D = 3700;
    localparam int MV_KNEE_E = 3550;
    localparam int LEVEL_STEP = 2;

    typedef struct packed {
        logic [6:0]         pct;
        logic signed [13:0] mv;
        logic               sampled;
    } t_reading;

    typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_BURSTS} t_stall_mode;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    t_cfg_index         i_cfg_index = CFG_MONITOR_ENABLE;
    logic [31:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [31:0]        i_now_ms = '0;
    logic signed [12:0] i_raw_sample = '0;
    logic               i_read_failed = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [6:0]         o_charge_percent;
    logic signed [13:0] o_supply_mv;
    logic               o_sampled;

    battery_gauge_hysteresis dut (.*);

    always #5 i_clk = ~i_clk;

    // gauge state as predicted
    logic               gauge_enable = RST_MONITOR_ENABLE;
    logic [31:0]        gauge_interval = RST_UPDATE_INTERVAL;
    logic [6:0]         gauge_level = 7'd100;
    logic signed [13:0] gauge_mv = '0;
    logic [31:0]        gauge_last = '0;
    logic               gauge_first = 1'b1;

    t_reading           pending_readings[$];
    t_reading           want;
    int                 mismatches = 0;
    int                 idle_cycles = 0;

    int                 burst_left = 1;
    bit                 gaps_on = 1'b1;
    logic signed [12:0] last_raw = 13'sd3200;

    int                 holdoff_len = 0;
    int                 holdoff_seq = 0;
    int                 holdoff_seen = 0;
    int                 hold_left = 0;
    t_stall_mode        stall_mode = STALL_NONE;
    int                 mode_left = 0;
    int                 run_left = 0;
    bit                 run_stall = 1'b0;

    function automatic int curve_percent(input int mv);
        if (mv >= MV_FULL) return 100;
        if (mv <= MV_EMPTY) return 0;
        if (mv >= MV_KNEE_A) return 90 + (mv - MV_KNEE_A) / 10;
        if (mv >= MV_KNEE_B) return 70 + (mv - MV_KNEE_B) / 5;
        if (mv >= MV_KNEE_C) return 40 + (mv - MV_KNEE_C) * 30 / 150;
        if (mv >= MV_KNEE_D) return 20 + (mv - MV_KNEE_D) * 20 / 150;
        if (mv >= MV_KNEE_E) return 5 + (mv - MV_KNEE_E) * 15 / 150;
        return (mv - MV_EMPTY) * 5 / 100;
    endfunction

    task automatic advance_gauge(input logic [31:0] now, input logic signed [12:0] raw,
                                 input logic failed);
        t_reading    r;
        logic [31:0] elapsed;
        int          prod;
        int          mv;
        int          pct;
        int          delta;
        r.sampled = 1'b0;
        if (gauge_enable) begin
            elapsed = now - gauge_last;
            if (gauge_first || elapsed >= gauge_interval) begin
                gauge_last = now;
                if (!failed) begin
                    prod = int'(raw) * 1200;
                    mv = (prod >>> 12) * 5;
                    pct = curve_percent(mv);
                    delta = pct - int'(gauge_level);
                    gauge_mv = 14'(mv);
                    if (gauge_first || delta >= LEVEL_STEP || delta <= -LEVEL_STEP) begin
                        gauge_level = 7'(pct);
                    end
                    gauge_first = 1'b0;
                    r.sampled = 1'b1;
                end
            end
        end
        r.pct = gauge_level;
        r.mv = gauge_mv;
        pending_readings.push_back(r);
    endtask

    // smallest raw code whose converted voltage reaches mv
    function automatic logic signed [12:0] raw_for_mv(input int mv);
        return 13'((mv / 5 * 4096 + 1199) / 1200);
    endfunction

    function automatic logic signed [12:0] pick_raw();
        int v;
        case ($urandom_range(0, 9))
            0, 1: return 13'($urandom());
            2, 3, 4, 5: begin
                v = int'(last_raw) + int'($urandom_range(0, 12)) - 6;
                return 13'(v);
            end
            default: return 13'($urandom_range(2860, 3590));
        endcase
    endfunction

    function automatic logic [31:0] pick_now();
        logic [31:0] off;
        case ($urandom_range(0, 6))
            0: off = gauge_interval;
            1: off = gauge_interval - 32'd1;
            2: off = gauge_interval + $urandom_range(1, 40);
            3: off = $urandom();
            4: off = $urandom_range(0, 20);
            default: off = $urandom_range(0, gauge_interval);
        endcase
        return gauge_last + off;
    endfunction

    task automatic send_reading(input logic [31:0] now, input logic signed [12:0] raw,
                                input logic failed);
        int gap;
        i_in_valid <= 1'b1;
        i_now_ms <= now;
        i_raw_sample <= raw;
        i_read_failed <= failed;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        advance_gauge(now, raw, failed);
        last_raw = raw;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = 0;
            if (gaps_on && $urandom_range(0, 2) != 0) gap = $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MONITOR_ENABLE) gauge_enable = data[0];
        else gauge_interval = data;
        @(posedge i_clk);
    endtask

    task automatic apply_config(input logic enable, input logic [31:0] interval);
        settle_idle();
        write_reg(CFG_MONITOR_ENABLE, {31'd0, enable});
        write_reg(CFG_UPDATE_INTERVAL, interval);
    endtask

    task automatic test_first_reading();
        send_reading(32'd5, raw_for_mv(3900), 1'b1);
        send_reading(32'd10, raw_for_mv(3900), 1'b0);
        send_reading(32'd100, raw_for_mv(3600), 1'b0);
        send_reading(32'd60010, raw_for_mv(4000), 1'b0);
    endtask

    task automatic test_charge_curve();
        int knees[7];
        knees = '{MV_FULL, MV_KNEE_A, MV_KNEE_B, MV_KNEE_C, MV_KNEE_D, MV_KNEE_E, MV_EMPTY};
        apply_config(1'b1, 32'd0);
        send_reading($urandom(), -13'sd4096, 1'b0);
        send_reading($urandom(), 13'sd4095, 1'b0);
        send_reading($urandom(), 13'sd0, 1'b0);
        send_reading($urandom(), -13'sd1, 1'b0);
        foreach (knees[k]) begin
            send_reading($urandom(), raw_for_mv(knees[k]), 1'b0);
            send_reading($urandom(), raw_for_mv(knees[k]) - 13'sd1, 1'b0);
        end
    endtask

    task automatic test_special_cases();
        send_reading($urandom(), 13'sd4095, 1'b1);
        apply_config(1'b0, 32'd0);
        send_reading($urandom(), raw_for_mv(4100), 1'b0);
        send_reading($urandom(), -13'sd4096, 1'b0);
        apply_config(1'b1, 32'hFFFF_FFFF);
        send_reading(gauge_last + 32'd5, raw_for_mv(3700), 1'b0);
        send_reading(gauge_last - 32'd1, raw_for_mv(3700), 1'b0);
        send_reading(gauge_last, raw_for_mv(4200), 1'b0);
        apply_config(1'b1, 32'd100);
        send_reading(32'hFFFF_FFC0, raw_for_mv(3850), 1'b0);
        send_reading(32'h0000_0030, raw_for_mv(3550), 1'b0);
        send_reading(32'h0000_0060, raw_for_mv(4000), 1'b0);
    endtask

    task automatic test_backpressure();
        settle_idle();
        holdoff_len = 80;
        holdoff_seq++;
        gaps_on = 1'b0;
        repeat (20) send_reading(pick_now(), pick_raw(), $urandom_range(0, 7) == 0);
        gaps_on = 1'b1;
        settle_idle();
    endtask

    task automatic test_random_phase(input logic enable, input logic [31:0] interval,
                                     input int count);
        apply_config(enable, interval);
        repeat (count) send_reading(pick_now(), pick_raw(), $urandom_range(0, 7) == 0);
    endtask

    // receiver stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (holdoff_seq != holdoff_seen) begin
            holdoff_seen = holdoff_seq;
            hold_left = holdoff_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left <= 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(30, 200);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                STALL_NONE: i_out_stall <= 1'b0;
                STALL_RANDOM: i_out_stall <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (run_left <= 0) begin
                        run_stall = ~run_stall;
                        run_left = $urandom_range(1, 6);
                    end else begin
                        run_left--;
                    end
                    i_out_stall <= run_stall;
                end
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected transfer: pct %0d mv %0d sampled %0b",
                             o_charge_percent, o_supply_mv, o_sampled);
                end
            end else begin
                want = pending_readings.pop_front();
                if (o_charge_percent !== want.pct || o_supply_mv !== want.mv ||
                    o_sampled !== want.sampled) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                                 want.pct, want.mv, want.sampled,
                                 o_charge_percent, o_supply_mv, o_sampled);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
            (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_first_reading();
        test_charge_curve();
        test_special_cases();
        test_backpressure();
        test_random_phase(1'b1, 32'd0, 150);
        test_random_phase(1'b1, $urandom_range(1, 100), 150);
        test_random_phase(1'b1, 32'd60000, 220);
        test_random_phase(1'b0, $urandom(), 40);
        test_random_phase(1'b1, 32'hFFFF_FFFF, 120);
        test_random_phase(1'b1, $urandom(), 150);
        test_random_phase(1'b1, 32'd1, 150);
        test_backpressure();
        settle_idle();
        repeat (8) @(posedge i_clk);
        mismatches += pending_readings.size();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
